// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_HOLDS(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/strf_pkg.sv =====
// Types, constants and helper functions of the SPI target register file.
package strf_pkg;

  localparam int REG_COUNT = 32;
  localparam int IDX_W     = $clog2(REG_COUNT);
  localparam int BYTE_W    = 8;
  localparam int FLAG_W    = 5;
  localparam int ADDR_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [BYTE_W-1:0] OPCODE_MASK = 8'b1100_0001;
  localparam logic [BYTE_W-1:0] ADDR_MASK   = 8'b0011_1110;

  localparam logic [IDX_W-1:0] TOGGLE_IDX_A = IDX_W'(8'h05);
  localparam logic [IDX_W-1:0] TOGGLE_IDX_B = IDX_W'(8'h0A);
  localparam logic [IDX_W-1:0] TOGGLE_IDX_C = IDX_W'(8'h0B);
  localparam logic [IDX_W-1:0] TOGGLE_IDX_D = IDX_W'(8'h0F);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRITE_CODE   = 3'd0,
    CFG_OWN_ADDRESS  = 3'd1,
    CFG_FLAG_INDEX   = 3'd2,
    CFG_ENABLE_CODE  = 3'd3,
    CFG_DISABLE_CODE = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_SELECT = 1'b0,
    OP_BYTE   = 1'b1
  } op_e;

  typedef struct packed {
    logic [BYTE_W-1:0] write_code;
    logic [ADDR_W-1:0] own_address;
    logic [FLAG_W-1:0] flag_index;
    logic [BYTE_W-1:0] enable_code;
    logic [BYTE_W-1:0] disable_code;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              drive_out;
    logic              reply_valid;
    logic [BYTE_W-1:0] reply_byte;
    logic              frame_done;
    logic              next_valid;
    logic [ADDR_W-1:0] next_addr;
  } out_item_t;

  function automatic logic is_toggle_index(input logic [IDX_W-1:0] idx);
    return (idx == TOGGLE_IDX_A) || (idx == TOGGLE_IDX_B) ||
           (idx == TOGGLE_IDX_C) || (idx == TOGGLE_IDX_D);
  endfunction

endpackage

// ===== design/strf_channels.sv =====
// Handshake channel interfaces for byte events and result transactions.
interface strf_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface strf_out_if;
  logic       valid;
  logic       ready;
  logic       drive_out;
  logic       reply_valid;
  logic [7:0] reply_byte;
  logic       frame_done;
  logic       next_valid;
  logic [2:0] next_addr;

  modport source (output valid, output drive_out, output reply_valid, output reply_byte,
                  output frame_done, output next_valid, output next_addr, input ready);
  modport sink (input valid, input drive_out, input reply_valid, input reply_byte,
                input frame_done, input next_valid, input next_addr, output ready);
endinterface

// ===== design/strf_cfg_regs.sv =====
// Configuration registers of the SPI target register file.
module strf_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [strf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [strf_pkg::BYTE_W-1:0]    cfg_wdata_i,
  output strf_pkg::cfg_t                 cfg_o
);
  import strf_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.write_code   <= '0;
      cfg_q.own_address  <= '0;
      cfg_q.flag_index   <= '0;
      cfg_q.enable_code  <= BYTE_W'(1);
      cfg_q.disable_code <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_WRITE_CODE:   cfg_q.write_code   <= cfg_wdata_i;
        CFG_OWN_ADDRESS:  cfg_q.own_address  <= cfg_wdata_i[ADDR_W-1:0];
        CFG_FLAG_INDEX:   cfg_q.flag_index   <= cfg_wdata_i[FLAG_W-1:0];
        CFG_ENABLE_CODE:  cfg_q.enable_code  <= cfg_wdata_i;
        CFG_DISABLE_CODE: cfg_q.disable_code <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/strf_core.sv =====
// Frame state, register store and per-event decode of the SPI target.
`include "assert_macros.svh"
module strf_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  strf_pkg::cfg_t      cfg_i,
  input  logic                fire_i,
  input  strf_pkg::in_item_t  item_i,
  output strf_pkg::out_item_t result_o
);
  import strf_pkg::*;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_INDEX  = 2'd1,
    PH_XFER   = 2'd2
  } phase_e;

  localparam logic [8:0] LAST_IDX = 9'(REG_COUNT - 1);

  phase_e            phase_q, phase_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [BYTE_W-1:0] opc_q, opc_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              chk_q, chk_d;
  logic              drv_q, drv_d;
  logic [BYTE_W-1:0] store_q [REG_COUNT];
  logic [REG_COUNT-1:0] nz_q;

  logic              store_we;
  logic              flag_clr;
  logic              skip;
  logic [IDX_W-1:0]  cur_idx;
  logic [IDX_W:0]    nxt_idx;
  logic [FLAG_W:0]   flag_pos;
  logic [IDX_W-1:0]  flag_idx;
  logic              flag_nz;
  logic [8:0]        read_code;
  logic [BYTE_W-1:0] rx;
  out_item_t         res;

  assign rx        = item_i.rx_byte;
  assign read_code = {1'b0, cfg_i.write_code} + 9'd1;
  assign flag_pos  = {1'b0, cfg_i.flag_index} + (FLAG_W + 1)'(1);
  assign flag_idx  = IDX_W'(flag_pos);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    opc_d    = opc_q;
    idx_d    = idx_q;
    chk_d    = chk_q;
    drv_d    = drv_q;
    store_we = 1'b0;
    flag_clr = 1'b0;
    skip     = 1'b0;
    cur_idx  = idx_q;
    nxt_idx  = '0;
    flag_nz  = 1'b0;
    res      = '0;
    if (item_i.op == OP_SELECT) begin
      phase_d = PH_OPCODE;
      cnt_d   = '0;
      drv_d   = 1'b0;
    end else begin
      if (cnt_q != 2'd3) begin
        cnt_d = cnt_q + 2'd1;
      end
      if (cnt_d == 2'd1) begin
        opc_d = rx & OPCODE_MASK;
        if (!chk_q || ((rx & ADDR_MASK) >> 1) == {5'b0, cfg_i.own_address}) begin
          phase_d = PH_INDEX;
          drv_d   = 1'b1;
        end else begin
          drv_d = 1'b0;
        end
      end else if (cnt_d == 2'd2 && phase_q == PH_INDEX) begin
        if ({1'b0, rx} < LAST_IDX) begin
          idx_d = IDX_W'(rx);
        end else begin
          idx_d = IDX_W'(LAST_IDX);
        end
        phase_d = PH_XFER;
        if (opc_q == cfg_i.write_code) begin
          skip = 1'b1;
        end
      end
      if (!skip && phase_d == PH_XFER) begin
        cur_idx = idx_d;
        if ({1'b0, opc_d} == read_code) begin
          res.reply_valid = 1'b1;
          res.reply_byte  = store_q[cur_idx];
        end else if (opc_d == cfg_i.write_code) begin
          if (is_toggle_index(cur_idx)) begin
            if (rx == cfg_i.enable_code) begin
              chk_d = 1'b1;
            end else if (rx == cfg_i.disable_code) begin
              chk_d = 1'b0;
            end
          end else begin
            store_we = 1'b1;
          end
        end
        nxt_idx = {1'b0, cur_idx} + (IDX_W + 1)'(1);
        if (32'(nxt_idx) >= REG_COUNT) begin
          idx_d          = '0;
          res.frame_done = 1'b1;
          if (store_we && cur_idx == flag_idx) begin
            flag_nz = (rx != '0);
          end else begin
            flag_nz = nz_q[flag_idx];
          end
          if (32'(flag_pos) < REG_COUNT && flag_nz) begin
            flag_clr       = 1'b1;
            res.next_valid = 1'b1;
            res.next_addr  = store_q[0][ADDR_W-1:0];
          end
        end else begin
          idx_d = nxt_idx[IDX_W-1:0];
        end
      end
    end
    res.drive_out = drv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      cnt_q   <= '0;
      opc_q   <= '0;
      idx_q   <= '0;
      chk_q   <= 1'b0;
      drv_q   <= 1'b0;
      nz_q    <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        store_q[i] <= '0;
      end
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      opc_q   <= opc_d;
      idx_q   <= idx_d;
      chk_q   <= chk_d;
      drv_q   <= drv_d;
      if (store_we) begin
        store_q[cur_idx] <= rx;
        nz_q[cur_idx]    <= (rx != '0);
      end
      if (flag_clr) begin
        store_q[flag_idx] <= '0;
        nz_q[flag_idx]    <= 1'b0;
      end
    end
  end

  assign result_o = res;

  `ASSERT_HOLDS(a_xfer_drives, clk_i, rst_ni,
    phase_q != PH_XFER || drv_q, "transfer phase without driven line")
  `ASSERT_CLK(a_done_wraps, clk_i, rst_ni,
    fire_i && res.frame_done |=> idx_q == '0, "index did not wrap at completion")
  `ASSERT_CLK(a_flag_cleared, clk_i, rst_ni,
    fire_i && res.next_valid |=> !nz_q[$past(flag_idx)], "flag register not cleared")

endmodule

// ===== design/spi_target_register_file_top.sv =====
// Top level of the SPI target register file with input and result registers.
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   op, rx_byte
//  out_ch   out  valid/ready   drive_out, reply_valid, reply_byte, frame_done,
//                              next_valid, next_addr
//  cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i
//
// Byte events are decoded at one transaction per clock while the result side is not stalled.
// An input transaction reaches the result through the input register, then the result register.
// The combinational decode logic between them reads the store at the index and at entry zero.
// Reset clears the frame state, the register store and the valid flags of both pipeline stages.
// A stalled result holds the result register; an empty input register still takes one more item.
`include "assert_macros.svh"
module spi_target_register_file_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  strf_in_if.sink                        in_ch,
  strf_out_if.source                     out_ch,
  input  logic                           cfg_we_i,
  input  logic [strf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [strf_pkg::BYTE_W-1:0]    cfg_wdata_i
);
  import strf_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item_q;
  logic      s1_valid_q;
  out_item_t result;
  out_item_t out_q;
  logic      out_valid_q;
  logic      advance;
  logic      in_fire;

  assign advance     = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  strf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  strf_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (advance),
    .item_i   (s1_item_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.op      <= in_ch.op;
      s1_item_q.rx_byte <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.drive_out   = out_q.drive_out;
  assign out_ch.reply_valid = out_q.reply_valid;
  assign out_ch.reply_byte  = out_q.reply_byte;
  assign out_ch.frame_done  = out_q.frame_done;
  assign out_ch.next_valid  = out_q.next_valid;
  assign out_ch.next_addr   = out_q.next_addr;

  `ASSERT_CLK(a_advance_loads, clk_i, rst_ni, advance |=> out_valid_q, "result register not loaded")
  `ASSERT_HOLDS(a_ready_low_full, clk_i, rst_ni, in_ch.ready || s1_valid_q, "input stalled while empty")
  `ASSERT_CLK(a_stage_holds, clk_i, rst_ni, s1_valid_q && !advance |=> s1_valid_q, "input stage item dropped")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the SPI target register file top level.
`timescale 1ns / 100ps

module testbench;
  import strf_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTING_COUNT = 7;
  localparam int RANDOM_EVENTS = 160;
  localparam int HOLD_AT       = 250;
  localparam int HOLD_CYCLES   = 100;
  localparam int LAST_REG      = REG_COUNT - 1;
  localparam logic [BYTE_W-1:0] UNUSED_OPCODE = 8'h81;

  typedef enum logic [1:0] {
    AWAIT_OPCODE,
    AWAIT_INDEX,
    TRANSFER
  } frame_phase_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BYTE_W-1:0]    cfg_wdata_i;

  strf_in_if  in_ch ();
  strf_out_if out_ch ();

  spi_target_register_file_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  in_item_t     byte_events[$];
  out_item_t    results_due[$];
  in_item_t     next_ev;
  in_item_t     taken_ev;
  out_item_t    predicted;
  out_item_t    got;
  out_item_t    want;

  cfg_t         cfg;
  frame_phase_e frame_phase;
  logic [1:0]   frame_bytes;
  logic [7:0]   frame_op;
  int           cur_index;
  bit           checking_on;
  bit           line_driven;
  logic [7:0]   regs [REG_COUNT];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_done;
  int events_taken;
  int results_seen;
  int replies_seen;
  int frames_done;
  int next_seen;
  int mismatches;
  int cycle_count;

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic step_event(input in_item_t ev, output out_item_t res);
    int         idx;
    int         flag_reg;
    logic [4:0] req;
    bit         skip;
    res  = '0;
    skip = 1'b0;
    if (ev.op == OP_SELECT) begin
      frame_phase = AWAIT_OPCODE;
      frame_bytes = 2'd0;
      line_driven = 1'b0;
    end else begin
      if (frame_bytes != 2'd3) frame_bytes = frame_bytes + 2'd1;
      if (frame_bytes == 2'd1) begin
        req      = ev.rx_byte[5:1];
        frame_op = ev.rx_byte & OPCODE_MASK;
        if (!checking_on || req == {2'b00, cfg.own_address}) begin
          frame_phase = AWAIT_INDEX;
          line_driven = 1'b1;
        end else begin
          line_driven = 1'b0;
        end
      end else if (frame_bytes == 2'd2 && frame_phase == AWAIT_INDEX) begin
        cur_index   = (int'(ev.rx_byte) < LAST_REG) ? int'(ev.rx_byte) : LAST_REG;
        frame_phase = TRANSFER;
        skip        = (frame_op == cfg.write_code);
      end
      if (!skip && frame_phase == TRANSFER) begin
        idx = (cur_index > LAST_REG) ? LAST_REG : cur_index;
        if ({1'b0, frame_op} == 9'(cfg.write_code) + 9'd1) begin
          res.reply_valid = 1'b1;
          res.reply_byte  = regs[idx];
        end else if (frame_op == cfg.write_code) begin
          if (idx == TOGGLE_IDX_A || idx == TOGGLE_IDX_B ||
              idx == TOGGLE_IDX_C || idx == TOGGLE_IDX_D) begin
            if (ev.rx_byte == cfg.enable_code) checking_on = 1'b1;
            else if (ev.rx_byte == cfg.disable_code) checking_on = 1'b0;
          end else begin
            regs[idx] = ev.rx_byte;
          end
        end
        cur_index = idx + 1;
        if (cur_index >= REG_COUNT) begin
          cur_index      = 0;
          res.frame_done = 1'b1;
          flag_reg       = 1 + int'(cfg.flag_index);
          if (flag_reg < REG_COUNT && regs[flag_reg] != 8'd0) begin
            regs[flag_reg] = 8'd0;
            res.next_valid = 1'b1;
            res.next_addr  = regs[0][2:0];
          end
        end
      end
    end
    res.drive_out = line_driven;
  endtask

  task automatic report_field(input string what, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) in_ch.valid <= 1'b0;
    else if (!in_ch.valid || in_ch.ready) begin
      if (byte_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_ev = byte_events.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.op      <= next_ev.op;
        in_ch.rx_byte <= next_ev.rx_byte;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && events_taken >= HOLD_AT) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      frame_phase = AWAIT_OPCODE;
      frame_bytes = 2'd0;
      frame_op    = 8'd0;
      cur_index   = 0;
      checking_on = 1'b0;
      line_driven = 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs[i] = 8'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_ev.op      = in_ch.op;
        taken_ev.rx_byte = in_ch.rx_byte;
        step_event(taken_ev, predicted);
        results_due.push_back(predicted);
        events_taken <= events_taken + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.drive_out   = out_ch.drive_out;
        got.reply_valid = out_ch.reply_valid;
        got.reply_byte  = out_ch.reply_byte;
        got.frame_done  = out_ch.frame_done;
        got.next_valid  = out_ch.next_valid;
        got.next_addr   = out_ch.next_addr;
        results_seen++;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          report_field("drive_out", want.drive_out, got.drive_out);
          report_field("reply_valid", want.reply_valid, got.reply_valid);
          report_field("reply_byte", want.reply_byte, got.reply_byte);
          report_field("frame_done", want.frame_done, got.frame_done);
          report_field("next_valid", want.next_valid, got.next_valid);
          report_field("next_addr", want.next_addr, got.next_addr);
          if (want.reply_valid) replies_seen++;
          if (want.frame_done) frames_done++;
          if (want.next_valid) next_seen++;
        end
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_WRITE_CODE:   cfg.write_code   = data;
      CFG_OWN_ADDRESS:  cfg.own_address  = data[ADDR_W-1:0];
      CFG_FLAG_INDEX:   cfg.flag_index   = data[FLAG_W-1:0];
      CFG_ENABLE_CODE:  cfg.enable_code  = data;
      CFG_DISABLE_CODE: cfg.disable_code = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_all_done();
    while (byte_events.size() != 0 || in_ch.valid || results_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic add_event(input logic op, input logic [BYTE_W-1:0] data);
    in_item_t ev;
    ev.op      = op;
    ev.rx_byte = data;
    byte_events.push_back(ev);
  endtask

  task automatic add_frame(input int n_data);
    logic [7:0]       masked;
    logic [4:0]       addr;
    logic [7:0]       idx_b;
    logic [IDX_W-1:0] toggle;
    logic [7:0]       data;
    case ($urandom_range(9))
      0, 1, 2, 3: masked = cfg.write_code;
      4, 5, 6, 7: masked = cfg.write_code + 8'd1;
      default:    masked = 8'($urandom_range(255));
    endcase
    masked = masked & OPCODE_MASK;
    addr = ($urandom_range(3) != 0) ? {2'b00, cfg.own_address} : 5'($urandom_range(31));
    add_event(OP_BYTE, masked | {2'b00, addr, 1'b0});
    case ($urandom_range(9))
      0, 1, 2, 3: idx_b = 8'($urandom_range(255));
      4, 5, 6:    idx_b = 8'($urandom_range(LAST_REG, LAST_REG - 7));
      7: begin
        case ($urandom_range(3))
          0:       toggle = TOGGLE_IDX_A;
          1:       toggle = TOGGLE_IDX_B;
          2:       toggle = TOGGLE_IDX_C;
          default: toggle = TOGGLE_IDX_D;
        endcase
        idx_b = 8'(toggle);
      end
      8:       idx_b = 8'(cfg.flag_index) + 8'd1;
      default: idx_b = 8'd0;
    endcase
    add_event(OP_BYTE, idx_b);
    for (int i = 0; i < n_data; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: data = 8'($urandom_range(255));
        5, 6:          data = cfg.enable_code;
        7:             data = cfg.disable_code;
        default:       data = 8'($urandom_range(7));
      endcase
      add_event(OP_BYTE, data);
    end
  endtask

  task automatic add_random(input int n_events);
    int n;
    while (byte_events.size() < n_events) begin
      case ($urandom_range(19))
        16, 17: begin
          n = $urandom_range(4, 1);
          for (int i = 0; i < n; i++) add_event(OP_BYTE, 8'($urandom_range(255)));
        end
        18: begin
          add_event(OP_SELECT, 8'($urandom_range(255)));
          add_event(OP_BYTE, 8'($urandom_range(255)));
        end
        19: add_event(OP_SELECT, 8'($urandom_range(255)));
        default: begin
          add_event(OP_SELECT, 8'($urandom_range(255)));
          add_frame(($urandom_range(7) == 0) ? $urandom_range(40, 20) : $urandom_range(6));
        end
      endcase
    end
  endtask

  task automatic add_directed();
    logic [7:0] wr_op;
    logic [7:0] rd_op;
    wr_op = cfg.write_code & OPCODE_MASK;
    rd_op = (cfg.write_code + 8'd1) & OPCODE_MASK;
    add_event(OP_SELECT, 8'hFF);
    add_event(OP_BYTE, wr_op);
    add_event(OP_BYTE, 8'h00);
    add_event(OP_BYTE, 8'hFE);
    add_event(OP_BYTE, 8'h01);
    add_event(OP_SELECT, 8'h00);
    add_event(OP_BYTE, rd_op);
    add_event(OP_BYTE, 8'hFF);
    add_event(OP_BYTE, 8'hAA);
    add_event(OP_SELECT, 8'h5A);
    add_event(OP_BYTE, UNUSED_OPCODE);
    add_event(OP_BYTE, 8'(LAST_REG));
    add_event(OP_BYTE, 8'h55);
    add_event(OP_SELECT, 8'h00);
    add_event(OP_BYTE, wr_op);
    add_event(OP_BYTE, 8'(TOGGLE_IDX_A));
    add_event(OP_BYTE, cfg.enable_code);
    add_event(OP_BYTE, 8'h12);
    add_event(OP_SELECT, 8'h00);
    add_event(OP_BYTE, wr_op | ADDR_MASK);
    add_event(OP_BYTE, 8'h00);
    add_event(OP_BYTE, 8'hFF);
    add_event(OP_SELECT, 8'h00);
    add_event(OP_BYTE, wr_op | {2'b00, 2'b00, cfg.own_address, 1'b0});
    add_event(OP_BYTE, 8'(TOGGLE_IDX_B));
    add_event(OP_BYTE, cfg.disable_code);
  endtask

  initial begin
    cfg_t setting;
    in_ch.valid   = 1'b0;
    in_ch.op      = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    hold_left     = 0;
    hold_done     = 1'b0;
    events_taken  = 0;
    results_seen  = 0;
    replies_seen  = 0;
    frames_done   = 0;
    next_seen     = 0;
    mismatches    = 0;
    cycle_count   = 0;
    send_idle_pct = 8;
    recv_idle_pct = 48;
    cfg = '{write_code: 8'h00, own_address: 3'd0, flag_index: 5'd0,
            enable_code: 8'h01, disable_code: 8'h00};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < SETTING_COUNT; p++) begin
      wait_all_done();
      case (p)
        0: setting = '{write_code: 8'h00, own_address: 3'd0, flag_index: 5'd0,
                       enable_code: 8'h01, disable_code: 8'h00};
        1: setting = '{write_code: 8'h40, own_address: 3'd7, flag_index: 5'd30,
                       enable_code: 8'hFF, disable_code: 8'h00};
        2: setting = '{write_code: 8'hC0, own_address: 3'd3, flag_index: 5'd4,
                       enable_code: 8'h5A, disable_code: 8'h5A};
        3: setting = '{write_code: 8'hFF, own_address: 3'd5, flag_index: 5'd31,
                       enable_code: 8'h00, disable_code: 8'hFF};
        4: setting = '{write_code: 8'h80, own_address: 3'd2, flag_index: 5'd0,
                       enable_code: 8'h81, disable_code: 8'h7E};
        5: setting = '{write_code: 8'hC1, own_address: 3'd6, flag_index: 5'd10,
                       enable_code: 8'h01, disable_code: 8'h02};
        default: setting = '{write_code: 8'h00, own_address: 3'd1, flag_index: 5'd15,
                             enable_code: 8'h33, disable_code: 8'hCC};
      endcase
      cfg_write(CFG_WRITE_CODE, setting.write_code);
      cfg_write(CFG_OWN_ADDRESS, 8'(setting.own_address));
      cfg_write(CFG_FLAG_INDEX, 8'(setting.flag_index));
      cfg_write(CFG_ENABLE_CODE, setting.enable_code);
      cfg_write(CFG_DISABLE_CODE, setting.disable_code);
      if (p == 3) begin
        for (int i = int'(CFG_DISABLE_CODE) + 1; i < (1 << CFG_IDX_W); i++)
          cfg_write(CFG_IDX_W'(i), 8'($urandom_range(255)));
      end
      if (p < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 48;
      end else if (p < 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0) add_directed();
      add_random(RANDOM_EVENTS);
    end

    wait_all_done();
    repeat (8) @(negedge clk_i);
    $display("summary: %0d byte events checked over %0d register settings, %0d results",
             events_taken, SETTING_COUNT, results_seen);
    $display("summary: %0d read replies, %0d completed frames, %0d next addresses",
             replies_seen, frames_done, next_seen);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/strf_pkg.sv
design/strf_channels.sv
design/strf_cfg_regs.sv
design/strf_core.sv
design/spi_target_register_file_top.sv
sim/testbench.sv
